[sv/bitmap_run_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Bitmap run allocator assertion macros
// Shorthand for clocked, reset-qualified assertions on the top level.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_ASSERT_SVH
`define BITMAP_RUN_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bra_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Shared field widths, command codes, sequencer states and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  // Positions, sizes and iteration counts all fit in the register width.
  localparam int unsigned POS_W = 11;

  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEST  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [POS_W-1:0] BITS_IN_USE_RESET = 11'd1024;

  localparam logic [2:0] REG_BITS_IN_USE = 3'd0;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_EV,
    ST_SET,
    ST_TEST_RD,
    ST_TEST_EV,
    ST_ERASE,
    ST_FIN
  } bra_state_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
  } bra_cmd_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] position;
  } bra_result_t;

  typedef struct packed {
    logic init_active;
    logic busy;
  } bra_status_t;

endpackage

`default_nettype wire

[sv/bitmap_run_allocator.sv]
// ----------------------------------------------------------------------------
// Bitmap run allocator
// Finds, sets, tests and clears runs of positions in an allocation bitmap.
// ----------------------------------------------------------------------------
// After reset the block sweeps the map clear, one position per cycle, and
// accepts no transaction meanwhile; register writes are taken at any time.
// It then handles one command at a time through a single memory read port
// with registered data. A find reads and evaluates each position it scans,
// then writes each bit of the run it found; a test reads and checks each
// position in turn, and a clear writes each position it clears. A finished
// result sits in an output register, so the next command can start while
// it waits to be taken.
`default_nettype none
`include "bitmap_run_allocator_assert.svh"

module bitmap_run_allocator #(
  parameter int unsigned MAP_BITS = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [bra_pkg::CMD_W-1:0] command_i,
  input  wire logic [bra_pkg::IDX_W-1:0] index_i,
  input  wire logic [bra_pkg::CNT_W-1:0] count_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           ok_o,
  output logic [bra_pkg::IDX_W-1:0]      position_o
);

  localparam int unsigned AW = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;

  logic [bra_pkg::POS_W-1:0] bits_in_use_q, bits_in_use_d;
  logic                      reg_sel_w;

  bra_pkg::bra_cmd_t    cmd;
  bra_pkg::bra_result_t res;
  bra_pkg::bra_status_t status;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  assign pready    = 1'b1;
  assign reg_sel_w = paddr == bra_pkg::REG_BITS_IN_USE;

  always_comb begin
    bits_in_use_d = bits_in_use_q;
    if (psel && penable && pwrite && pready && reg_sel_w) begin
      bits_in_use_d = pwdata[bra_pkg::POS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel_w) prdata = {21'd0, bits_in_use_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_in_use_q <= bra_pkg::BITS_IN_USE_RESET;
    end else begin
      bits_in_use_q <= bits_in_use_d;
    end
  end

  assign cmd.command = command_i;
  assign cmd.index   = index_i;
  assign cmd.count   = count_i;

  bra_seq #(
    .MAP_BITS (MAP_BITS),
    .AW       (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bits_in_use_i (bits_in_use_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .res_o         (res),
    .status_o      (status),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  bra_map_ram #(
    .DEPTH (MAP_BITS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ok_o       = res.ok;
  assign position_o = res.position;

  `BRA_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o && status.busy, "command accepted but sequencer did not leave idle")
  `BRA_ASSERT_IMP(a_no_accept_in_init, status.init_active, !in_ready_o, "ready raised during the map clearing sweep")
  `BRA_ASSERT_IMP(a_fail_pos_zero, out_valid_o && !ok_o, position_o == '0, "failed result carries a nonzero position")

endmodule

`default_nettype wire

[sv/bra_map_ram.sv]
// ----------------------------------------------------------------------------
// Bitmap run allocator map memory
// One bit per position, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_map_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic          wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic               rdata_o
);

  logic mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/bra_seq.sv]
// ----------------------------------------------------------------------------
// Bitmap run allocator sequencer
// Walks the map one position at a time with a shared wrapping step unit,
// runs the find, set, test and clear passes and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_seq #(
  parameter int unsigned MAP_BITS = 1024,
  parameter int unsigned AW       = 10
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [bra_pkg::POS_W-1:0] bits_in_use_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire bra_pkg::bra_cmd_t         cmd_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output bra_pkg::bra_result_t           res_o,
  output bra_pkg::bra_status_t           status_o,
  output logic                           ram_we_o,
  output logic [AW-1:0]                  ram_waddr_o,
  output logic                           ram_wdata_o,
  output logic [AW-1:0]                  ram_raddr_o,
  input  wire logic                      ram_rdata_i
);

  localparam int unsigned PW = bra_pkg::POS_W;
  localparam logic [31:0] MapBits32 = 32'(MAP_BITS);
  localparam logic [AW-1:0] LastAddr = AW'(MAP_BITS - 1);

  bra_pkg::bra_state_e state_q, state_d;

  logic [AW-1:0] clr_q, clr_d;
  logic [PW-1:0] n_q, n_d;
  logic [PW-1:0] lim_q, lim_d;
  logic [PW-1:0] p_q, p_d;
  logic [PW-1:0] i_q, i_d;
  logic [PW-1:0] run_q, run_d;
  logic [PW-1:0] start_q, start_d;
  logic          ok_q, ok_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          out_valid_q, out_valid_d;
  bra_pkg::bra_result_t res_q, res_d;

  logic [PW-1:0] n_w;
  logic [PW-1:0] cnt_w;
  logic [PW-1:0] idx_w;
  logic [PW-1:0] lim_w;
  logic          find_ok_w;
  logic          idx_in_w;
  logic          accept_w;
  logic          fin_load_w;

  // Shared step unit: one increment with wrap for the position, and one each
  // for the iteration count and the run length.
  logic [PW-1:0] pos_inc_w;
  logic [PW-1:0] pos_next_w;
  logic [PW-1:0] iter_inc_w;
  logic [PW-1:0] run_inc_w;
  logic          found_w;

  // A size of zero acts as one and a size above the map acts as the map.
  always_comb begin
    if (bits_in_use_i == '0) begin
      n_w = PW'(1);
    end else if ({21'd0, bits_in_use_i} > MapBits32) begin
      n_w = PW'(MAP_BITS);
    end else begin
      n_w = bits_in_use_i;
    end
  end

  assign cnt_w     = cmd_i.count;
  assign idx_w     = {1'b0, cmd_i.index};
  assign lim_w     = (cnt_w < n_w) ? cnt_w : n_w;
  assign find_ok_w = (cnt_w != '0) && (cnt_w <= n_w);
  assign idx_in_w  = idx_w < n_w;
  assign accept_w  = (state_q == bra_pkg::ST_IDLE) && in_valid_i;
  assign fin_load_w = (state_q == bra_pkg::ST_FIN) && (!out_valid_q || out_ready_i);

  assign pos_inc_w  = p_q + PW'(1);
  assign pos_next_w = (pos_inc_w >= n_q) ? '0 : pos_inc_w;
  assign iter_inc_w = i_q + PW'(1);
  assign run_inc_w  = run_q + PW'(1);
  assign found_w    = (ram_rdata_i == 1'b0) && (run_inc_w >= lim_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bra_pkg::ST_INIT: begin
        if (clr_q == LastAddr) state_d = bra_pkg::ST_IDLE;
      end
      bra_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i.command)
            bra_pkg::CMD_FIND: begin
              state_d = find_ok_w ? bra_pkg::ST_FIND_RD : bra_pkg::ST_FIN;
            end
            bra_pkg::CMD_TEST: begin
              state_d = (idx_in_w && lim_w != '0) ? bra_pkg::ST_TEST_RD : bra_pkg::ST_FIN;
            end
            bra_pkg::CMD_CLEAR: begin
              state_d = (idx_in_w && lim_w != '0) ? bra_pkg::ST_ERASE : bra_pkg::ST_FIN;
            end
            default: state_d = bra_pkg::ST_FIN;
          endcase
        end
      end
      bra_pkg::ST_FIND_RD: state_d = bra_pkg::ST_FIND_EV;
      bra_pkg::ST_FIND_EV: begin
        if (found_w) begin
          state_d = bra_pkg::ST_SET;
        end else if (iter_inc_w == n_q) begin
          state_d = bra_pkg::ST_FIN;
        end else begin
          state_d = bra_pkg::ST_FIND_RD;
        end
      end
      bra_pkg::ST_SET: begin
        if (iter_inc_w == lim_q) state_d = bra_pkg::ST_FIN;
      end
      bra_pkg::ST_TEST_RD: state_d = bra_pkg::ST_TEST_EV;
      bra_pkg::ST_TEST_EV: begin
        if (ram_rdata_i == 1'b0 || iter_inc_w == lim_q) begin
          state_d = bra_pkg::ST_FIN;
        end else begin
          state_d = bra_pkg::ST_TEST_RD;
        end
      end
      bra_pkg::ST_ERASE: begin
        if (iter_inc_w == lim_q) state_d = bra_pkg::ST_FIN;
      end
      bra_pkg::ST_FIN: begin
        if (fin_load_w) state_d = bra_pkg::ST_IDLE;
      end
      default: state_d = bra_pkg::ST_IDLE;
    endcase
  end

  // Memory port, handshake and status outputs.
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(p_q);
    ram_wdata_o = 1'b0;
    ram_raddr_o = AW'(p_q);
    in_ready_o  = 1'b0;
    status_o.init_active = 1'b0;
    status_o.busy        = 1'b1;
    case (state_q)
      bra_pkg::ST_INIT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        status_o.init_active = 1'b1;
      end
      bra_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        status_o.busy = 1'b0;
      end
      bra_pkg::ST_SET: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = 1'b1;
      end
      bra_pkg::ST_ERASE: begin
        ram_we_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Datapath registers.
  always_comb begin
    clr_d   = clr_q;
    n_d     = n_q;
    lim_d   = lim_q;
    p_d     = p_q;
    i_d     = i_q;
    run_d   = run_q;
    start_d = start_q;
    ok_d    = ok_q;
    pos_d   = pos_q;
    case (state_q)
      bra_pkg::ST_INIT: begin
        clr_d = clr_q + AW'(1);
      end
      bra_pkg::ST_IDLE: begin
        if (accept_w) begin
          n_d   = n_w;
          i_d   = '0;
          run_d = '0;
          ok_d  = 1'b0;
          pos_d = '0;
          if (cmd_i.command == bra_pkg::CMD_FIND) begin
            lim_d = cnt_w;
            p_d   = idx_in_w ? idx_w : '0;
          end else begin
            lim_d = lim_w;
            p_d   = idx_w;
            // A zero count on an in-range start succeeds at once.
            if ((cmd_i.command == bra_pkg::CMD_TEST || cmd_i.command == bra_pkg::CMD_CLEAR)
                && idx_in_w && lim_w == '0) begin
              ok_d = 1'b1;
            end
          end
        end
      end
      bra_pkg::ST_FIND_EV: begin
        if (ram_rdata_i == 1'b0) begin
          if (run_q == '0) start_d = p_q;
          run_d = run_inc_w;
        end else begin
          run_d = '0;
        end
        if (found_w) begin
          p_d = (run_q == '0) ? p_q : start_q;
          i_d = '0;
        end else begin
          p_d = pos_next_w;
          i_d = iter_inc_w;
        end
      end
      bra_pkg::ST_SET: begin
        p_d = pos_next_w;
        i_d = iter_inc_w;
        if (iter_inc_w == lim_q) begin
          ok_d  = 1'b1;
          pos_d = start_q;
        end
      end
      bra_pkg::ST_TEST_EV: begin
        p_d = pos_next_w;
        i_d = iter_inc_w;
        if (ram_rdata_i != 1'b0 && iter_inc_w == lim_q) ok_d = 1'b1;
      end
      bra_pkg::ST_ERASE: begin
        p_d = pos_next_w;
        i_d = iter_inc_w;
        if (iter_inc_w == lim_q) ok_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result register: frees the sequencer while a result waits to be taken.
  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (fin_load_w) begin
      res_d.ok       = ok_q;
      res_d.position = pos_q[bra_pkg::IDX_W-1:0];
      out_valid_d    = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bra_pkg::ST_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    lim_q   <= lim_d;
    p_q     <= p_d;
    i_q     <= i_d;
    run_q   <= run_d;
    start_q <= start_d;
    ok_q    <= ok_d;
    pos_q   <= pos_d;
    res_q   <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Bitmap run allocator testbench
// Drives find, test and clear commands through the valid/ready input channel
// and checks every result against a typed value or a cycle-free predictor
// of the bitmap. A short table of directed commands comes first, then random
// phases at several bitmap sizes, written over the APB port while idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MAP_BITS = 1024;
  localparam logic [bra_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned NUM_DIR_ROWS = 26;
  localparam int unsigned NUM_PHASES = 9;
  localparam int unsigned TAIL_CYCLES = 3200;

  // One directed command, with its expected result where it is typed in.
  typedef struct packed {
    logic [bra_pkg::CNT_W-1:0] size;
    logic [bra_pkg::CMD_W-1:0] command;
    logic [bra_pkg::IDX_W-1:0] index;
    logic [bra_pkg::CNT_W-1:0] count;
    logic                      typed;
    logic                      ok;
    logic [bra_pkg::IDX_W-1:0] position;
  } dir_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [2:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [bra_pkg::CMD_W-1:0] command_i = '0;
  logic [bra_pkg::IDX_W-1:0] index_i = '0;
  logic [bra_pkg::CNT_W-1:0] count_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic                      ok_o;
  logic [bra_pkg::IDX_W-1:0] position_o;

  // Predictor state: the bitmap and the size register as the block holds them.
  bit                        alloc_map [MAP_BITS];
  logic [bra_pkg::CNT_W-1:0] cfg_bits_in_use = bra_pkg::BITS_IN_USE_RESET;

  bra_pkg::bra_result_t      awaited_outcomes [$];
  bra_pkg::bra_result_t      want;
  int                        err_count = 0;
  int                        send_idle_pct = 21;
  int                        recv_idle_pct = 63;
  bit                        stall_request = 1'b0;
  int                        hold_left = 0;
  bit                        have_alloc = 1'b0;
  logic [bra_pkg::IDX_W-1:0] last_alloc_pos = '0;
  logic [bra_pkg::CNT_W-1:0] last_alloc_cnt = '0;

  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    {11'd1024, bra_pkg::CMD_TEST,  10'd0,    11'd1,    1'b1, 1'b0, 10'd0},
    {11'd1024, bra_pkg::CMD_FIND,  10'd0,    11'd1,    1'b1, 1'b1, 10'd0},
    {11'd1024, bra_pkg::CMD_TEST,  10'd0,    11'd1,    1'b1, 1'b1, 10'd0},
    {11'd1024, bra_pkg::CMD_FIND,  10'd1023, 11'd1,    1'b1, 1'b1, 10'd1023},
    {11'd1024, bra_pkg::CMD_FIND,  10'd1023, 11'd2,    1'b0, 1'b0, 10'd0},
    {11'd1024, bra_pkg::CMD_TEST,  10'd1023, 11'd2,    1'b0, 1'b0, 10'd0},
    {11'd1024, bra_pkg::CMD_CLEAR, 10'd0,    11'd1024, 1'b1, 1'b1, 10'd0},
    {11'd1024, bra_pkg::CMD_FIND,  10'd0,    11'd1024, 1'b1, 1'b1, 10'd0},
    {11'd1024, bra_pkg::CMD_FIND,  10'd5,    11'd1,    1'b1, 1'b0, 10'd0},
    {11'd1024, bra_pkg::CMD_TEST,  10'd0,    11'd1024, 1'b1, 1'b1, 10'd0},
    {11'd1024, bra_pkg::CMD_CLEAR, 10'd1023, 11'd2047, 1'b1, 1'b1, 10'd0},
    {11'd1024, bra_pkg::CMD_FIND,  10'd0,    11'd0,    1'b1, 1'b0, 10'd0},
    {11'd1024, bra_pkg::CMD_TEST,  10'd3,    11'd0,    1'b1, 1'b1, 10'd0},
    {11'd1024, bra_pkg::CMD_CLEAR, 10'd1023, 11'd0,    1'b1, 1'b1, 10'd0},
    {11'd1024, CMD_UNUSED,         10'd5,    11'd5,    1'b1, 1'b0, 10'd0},
    {11'd1024, bra_pkg::CMD_FIND,  10'd0,    11'd2047, 1'b1, 1'b0, 10'd0},
    {11'd1024, bra_pkg::CMD_FIND,  10'd100,  11'd10,   1'b1, 1'b1, 10'd100},
    {11'd16,   bra_pkg::CMD_TEST,  10'd16,   11'd1,    1'b1, 1'b0, 10'd0},
    {11'd16,   bra_pkg::CMD_CLEAR, 10'd20,   11'd1,    1'b1, 1'b0, 10'd0},
    {11'd16,   bra_pkg::CMD_FIND,  10'd20,   11'd4,    1'b0, 1'b0, 10'd0},
    {11'd16,   bra_pkg::CMD_FIND,  10'd14,   11'd4,    1'b0, 1'b0, 10'd0},
    {11'd16,   bra_pkg::CMD_CLEAR, 10'd0,    11'd1,    1'b1, 1'b1, 10'd0},
    {11'd16,   bra_pkg::CMD_FIND,  10'd14,   11'd3,    1'b0, 1'b0, 10'd0},
    {11'd0,    bra_pkg::CMD_FIND,  10'd5,    11'd1,    1'b0, 1'b0, 10'd0},
    {11'd0,    bra_pkg::CMD_CLEAR, 10'd0,    11'd5,    1'b1, 1'b1, 10'd0},
    {11'd2047, bra_pkg::CMD_TEST,  10'd100,  11'd10,   1'b0, 1'b0, 10'd0}
  };

  logic [bra_pkg::CNT_W-1:0] phase_size [NUM_PHASES] =
    '{11'd16, 11'd1024, 11'd1, 11'd64, 11'd0, 11'd200, 11'd2047, 11'd37, 11'd8};
  int phase_items [NUM_PHASES] = '{120, 40, 20, 120, 20, 80, 30, 120, 100};
  int phase_send  [NUM_PHASES] = '{21, 21, 21, 63, 63, 63, 0, 0, 0};
  int phase_recv  [NUM_PHASES] = '{63, 63, 63, 21, 21, 21, 0, 0, 0};
  bit phase_hold  [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 1, 0};

  bitmap_run_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .index_i     (index_i),
    .count_i     (count_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .position_o  (position_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned eff_size(input logic [bra_pkg::CNT_W-1:0] raw);
    if (raw == 0) begin
      return 1;
    end
    if (raw > MAP_BITS) begin
      return MAP_BITS;
    end
    return {21'd0, raw};
  endfunction

  function automatic int unsigned next_slot(input int unsigned p, input int unsigned n);
    return (p + 1 >= n) ? 0 : p + 1;
  endfunction

  // Applies one command to the predicted bitmap and returns its result.
  function automatic bra_pkg::bra_result_t bitmap_op_outcome(
      input logic [bra_pkg::CMD_W-1:0] cmd,
      input logic [bra_pkg::IDX_W-1:0] idx,
      input logic [bra_pkg::CNT_W-1:0] cnt);
    int unsigned          n, run, run_start, p, lim, i;
    bit                   found;
    bra_pkg::bra_result_t res;
    n = eff_size(cfg_bits_in_use);
    res = '0;
    run = 0;
    run_start = 0;
    found = 1'b0;
    lim = (cnt < n) ? {21'd0, cnt} : n;
    case (cmd)
      bra_pkg::CMD_FIND: begin
        if (cnt != 0 && cnt <= n) begin
          p = (idx < n) ? {22'd0, idx} : 0;
          for (i = 0; i < n && !found; i++) begin
            if (!alloc_map[p]) begin
              if (run == 0) begin
                run_start = p;
              end
              run++;
              if (run >= cnt) begin
                found = 1'b1;
              end
            end else begin
              run = 0;
            end
            p = next_slot(p, n);
          end
          if (found) begin
            p = run_start;
            for (i = 0; i < cnt; i++) begin
              alloc_map[p] = 1'b1;
              p = next_slot(p, n);
            end
            res.ok = 1'b1;
            res.position = run_start[bra_pkg::IDX_W-1:0];
          end
        end
      end
      bra_pkg::CMD_TEST: begin
        if (idx < n) begin
          res.ok = 1'b1;
          p = {22'd0, idx};
          for (i = 0; i < lim && res.ok; i++) begin
            if (!alloc_map[p]) begin
              res.ok = 1'b0;
            end
            p = next_slot(p, n);
          end
        end
      end
      bra_pkg::CMD_CLEAR: begin
        if (idx < n) begin
          p = {22'd0, idx};
          for (i = 0; i < lim; i++) begin
            alloc_map[p] = 1'b0;
            p = next_slot(p, n);
          end
          res.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Offers one command and records its expected result once it is accepted.
  task automatic send_item(input logic [bra_pkg::CMD_W-1:0] cmd,
                           input logic [bra_pkg::IDX_W-1:0] idx,
                           input logic [bra_pkg::CNT_W-1:0] cnt, input bit typed,
                           input bra_pkg::bra_result_t typed_res);
    bra_pkg::bra_result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    index_i <= idx;
    count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    pred = bitmap_op_outcome(cmd, idx, cnt);
    if (cmd == bra_pkg::CMD_FIND && pred.ok) begin
      have_alloc = 1'b1;
      last_alloc_pos = pred.position;
      last_alloc_cnt = cnt;
    end
    awaited_outcomes.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain_outcomes();
    in_valid_i <= 1'b0;
    while (awaited_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Writes the size register, then reads it back.
  task automatic write_bits_in_use(input logic [bra_pkg::CNT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= bra_pkg::REG_BITS_IN_USE;
    pwdata <= {21'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_bits_in_use = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {21'd0, value}) begin
      $display("%0t: bits_in_use readback expected %0d actual %0d", $time, value, prdata);
      err_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: random stalls, or one long hold-off when the stimulus asks.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (stall_request) begin
      stall_request = 1'b0;
      hold_left = 400;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: unexpected result ok %0b position %0d", $time, ok_o, position_o);
        err_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (ok_o !== want.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, ok_o);
          err_count++;
        end
        if (position_o !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   position_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    int                        k, ph, j, r;
    int unsigned               n, u;
    dir_row_t                  row;
    logic [bra_pkg::CMD_W-1:0] cmd;
    logic [bra_pkg::IDX_W-1:0] idx;
    logic [bra_pkg::CNT_W-1:0] cnt;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < NUM_DIR_ROWS; k++) begin
      row = dir_rows[k];
      if (row.size != cfg_bits_in_use) begin
        drain_outcomes();
        write_bits_in_use(row.size);
      end
      send_item(row.command, row.index, row.count, row.typed, {row.ok, row.position});
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_outcomes();
      write_bits_in_use(phase_size[ph]);
      send_idle_pct = phase_send[ph];
      recv_idle_pct = phase_recv[ph];
      // The long hold-off lets the output register and the engine both fill.
      if (phase_hold[ph]) begin
        stall_request = 1'b1;
      end
      n = eff_size(cfg_bits_in_use);
      for (j = 0; j < phase_items[ph]; j++) begin
        r = $urandom_range(99);
        if (r < 40) begin
          cmd = bra_pkg::CMD_FIND;
        end else if (r < 65) begin
          cmd = bra_pkg::CMD_TEST;
        end else if (r < 95) begin
          cmd = bra_pkg::CMD_CLEAR;
        end else begin
          cmd = CMD_UNUSED;
        end
        if ($urandom_range(9) == 0) begin
          u = $urandom_range(MAP_BITS - 1);
        end else begin
          u = $urandom_range(n - 1);
        end
        idx = u[bra_pkg::IDX_W-1:0];
        r = $urandom_range(19);
        if (r == 0) begin
          u = 0;
        end else if (r == 1) begin
          u = $urandom_range(2047);
        end else if (r == 2) begin
          u = n;
        end else if (r == 3) begin
          u = n + $urandom_range(3);
        end else begin
          u = $urandom_range((n < 8) ? n : 8, 1);
        end
        cnt = u[bra_pkg::CNT_W-1:0];
        // Aim half of the tests, clears and unused commands at the most recent allocation.
        if (have_alloc && cmd != bra_pkg::CMD_FIND && last_alloc_pos < n
            && $urandom_range(1)) begin
          idx = last_alloc_pos;
          u = $urandom_range({21'd0, last_alloc_cnt}, 1);
          cnt = u[bra_pkg::CNT_W-1:0];
        end
        send_item(cmd, idx, cnt, 1'b0, '0);
      end
    end

    drain_outcomes();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
